// File: hw/rtl/fpe_pkg.sv
// Shared types, character codes and helpers of the formatted print engine.
package fpe_pkg;

  localparam int OpW   = 2;
  localparam int CharW = 8;
  localparam int ArgW  = 32;
  localparam int CntW  = 6;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_FMT = 2'd0,
    OP_ARG = 2'd1,
    OP_END = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_BIN  = 2'd2,
    MODE_WAIT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DEC  = 2'd0,
    KIND_HEXL = 2'd1,
    KIND_HEXU = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_DABBLE = 2'd1,
    BK_DIGITS = 2'd2,
    BK_HELD   = 2'd3
  } back_state_e;

  typedef enum logic {
    CMD_CHAR  = 1'b0,
    CMD_PRINT = 1'b1
  } cmd_e;

  localparam logic [CharW-1:0] ChrPct  = 8'h25;
  localparam logic [CharW-1:0] ChrB    = 8'h62;
  localparam logic [CharW-1:0] ChrW    = 8'h77;
  localparam logic [CharW-1:0] ChrD    = 8'h64;
  localparam logic [CharW-1:0] ChrLx   = 8'h78;
  localparam logic [CharW-1:0] ChrUx   = 8'h58;
  localparam logic [CharW-1:0] ChrZero = 8'h30;

  localparam logic [CntW-1:0] BinBits8  = 6'd8;
  localparam logic [CntW-1:0] BinBits16 = 6'd16;
  localparam logic [CntW-1:0] BinBits32 = 6'd32;
  localparam logic [CntW-1:0] HexDigits = 6'd8;

  localparam logic [CharW-1:0] HexUpper [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [CharW-1:0] HexLower [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // One command word handed from the parser to the printer.
  typedef struct packed {
    cmd_e                  kind;
    kind_e                 conv;
    logic [CntW-1:0]       nbits;
    logic [ArgW-1:0]       value;
    logic [CharW-1:0]      chr;
    logic                  held_en;
  } cmd_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib, input logic upper);
    return upper ? HexUpper[nib] : HexLower[nib];
  endfunction

endpackage

// File: hw/rtl/fpe_stream_if.sv
// Valid/ready channel interfaces for the input words and the output characters.
interface fpe_in_if import fpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [CharW-1:0] fmt_byte;
  logic [ArgW-1:0]  arg;

  modport source (output valid, output op, output fmt_byte, output arg, input ready);
  modport sink   (input valid, input op, input fmt_byte, input arg, output ready);
endinterface

interface fpe_out_if import fpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: hw/rtl/formatted_print_engine.sv
// Top level of the formatted print engine: parser, command queue and printer.
// The parser takes one word per cycle while the queue is not full; a plain character passes
// through the queue and the output register. The printer picks up a conversion, then emits
// at most one character per cycle while the output is taken: %x prints 8 digits, binary 8, 16
// or 32; %d converts ARG_WIDTH (at most 32) bits, then walks its digit places; a held char ends it.
// Reset clears the parse state, the queue and the output register; no clearing pass is needed.
module formatted_print_engine import fpe_pkg::*; #(
  parameter int ARG_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpe_in_if.sink     in_i,
  fpe_out_if.source  out_o
);

  // Command path between the parser and the printer. The queue decouples the two so that
  // format words keep flowing while a long conversion is still printing.
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  // The parser owns the format state machine. It decides everything about an input word in
  // the cycle the word is taken and turns it into at most one command.
  fpe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  fpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out),
    .empty_o (q_empty)
  );

  // The printer converts decimal values with a shift-and-add-three loop, one argument bit per
  // cycle, and then streams digits through its output register, which holds a finished
  // character while the parser keeps accepting words as long as the queue has room.
  fpe_back #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // The parser never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // A command is only issued for an input word taken in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> (in_i.valid && in_i.ready))
    else $error("command issued without an accepted word");

  // The printer only takes commands that are present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

endmodule

// File: hw/rtl/fpe_front.sv
// Format parser: accepts input words, tracks the conversion state and issues commands.
module fpe_front import fpe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  fpe_in_if.sink in_i,
  input  logic   q_full_i,
  output logic   q_push_o,
  output cmd_t   q_cmd_o
);

  mode_e            mode_q, mode_d;
  kind_e            kind_q, kind_d;
  logic [CntW-1:0]  bits_q, bits_d;
  logic [CharW-1:0] held_q, held_d;
  logic             held_vld_q, held_vld_d;
  logic             fire;
  op_e              op;
  logic [CharW-1:0] c;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);
  assign c          = in_i.fmt_byte;

  // Next parse state.
  always_comb begin
    mode_d     = mode_q;
    kind_d     = kind_q;
    bits_d     = bits_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (fire) begin
      case (op)
        OP_FMT: begin
          case (mode_q)
            MODE_PCT: begin
              mode_d = MODE_TEXT;
              if (c == ChrD) begin
                kind_d = KIND_DEC;
                mode_d = MODE_WAIT;
              end else if (c == ChrLx) begin
                kind_d = KIND_HEXL;
                mode_d = MODE_WAIT;
              end else if (c == ChrUx) begin
                kind_d = KIND_HEXU;
                mode_d = MODE_WAIT;
              end else if (c == ChrB) begin
                mode_d = MODE_BIN;
              end
            end
            MODE_BIN: begin
              kind_d = KIND_BIN;
              mode_d = MODE_WAIT;
              if (c == ChrB) begin
                bits_d = BinBits8;
              end else if (c == ChrW) begin
                bits_d = BinBits16;
              end else if (c == ChrD) begin
                bits_d = BinBits32;
              end else begin
                bits_d     = BinBits32;
                held_d     = c;
                held_vld_d = 1'b1;
              end
            end
            MODE_WAIT: begin
              held_d     = '0;
              held_vld_d = 1'b0;
              mode_d     = (c == ChrPct) ? MODE_PCT : MODE_TEXT;
            end
            default: begin
              mode_d = (c == ChrPct) ? MODE_PCT : MODE_TEXT;
            end
          endcase
        end
        OP_ARG: begin
          if (mode_q == MODE_WAIT) begin
            // A held percent sign opens a new conversion instead of printing.
            mode_d     = (held_vld_q && held_q == ChrPct) ? MODE_PCT : MODE_TEXT;
            held_d     = '0;
            held_vld_d = 1'b0;
          end
        end
        OP_END: begin
          mode_d     = MODE_TEXT;
          held_d     = '0;
          held_vld_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Command issue.
  always_comb begin
    q_push_o        = 1'b0;
    q_cmd_o.kind    = CMD_CHAR;
    q_cmd_o.conv    = kind_q;
    q_cmd_o.nbits   = bits_q;
    q_cmd_o.value   = in_i.arg;
    q_cmd_o.chr     = c;
    q_cmd_o.held_en = 1'b0;
    if (fire) begin
      case (op)
        OP_FMT: begin
          case (mode_q)
            MODE_PCT:  q_push_o = (c == ChrPct);
            MODE_BIN:  q_push_o = 1'b0;
            default:   q_push_o = (c != ChrPct);
          endcase
        end
        OP_ARG: begin
          if (mode_q == MODE_WAIT) begin
            q_push_o        = 1'b1;
            q_cmd_o.kind    = CMD_PRINT;
            q_cmd_o.chr     = held_q;
            q_cmd_o.held_en = held_vld_q && (held_q != ChrPct);
          end
        end
        default: q_push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_TEXT;
      kind_q     <= KIND_DEC;
      bits_q     <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      kind_q     <= kind_d;
      bits_q     <= bits_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule

// File: hw/rtl/fpe_queue.sv
// Two-entry command queue between the parser and the printer.
module fpe_queue import fpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hw/rtl/fpe_back.sv
// Printer: runs commands; at most one character per cycle enters the output register.
module fpe_back import fpe_pkg::*; #(
  parameter int ARG_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  fpe_out_if.source  out_o
);

  localparam int ValW   = (ARG_WIDTH < ArgW) ? ARG_WIDTH : ArgW;
  localparam int NumDig = (ValW * 30103) / 100000 + 1;
  localparam int BcdW   = NumDig * 4;

  back_state_e      state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [ArgW-1:0]  sh_q, sh_d;
  logic [ValW-1:0]  val_q, val_d;
  logic [BcdW-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CharW-1:0] held_q, held_d;
  logic             held_en_q, held_en_d;
  logic             started_q, started_d;
  logic             ovld_q, ovld_d;
  logic [CharW-1:0] ochr_q, ochr_d;
  logic             olast_q, olast_d;

  logic             ofree;
  logic             cnt_last;
  logic             skip;
  logic [3:0]       dec_nib;
  logic [CharW-1:0] digit_chr;
  logic [ArgW-1:0]  val32;

  assign out_o.valid    = ovld_q;
  assign out_o.out_char = ochr_q;
  assign out_o.last     = olast_q;

  assign ofree    = !ovld_q || out_o.ready;
  assign cnt_last = (cnt_q == CntW'(1));
  assign dec_nib  = bcd_q[BcdW-1 -: 4];
  // Leading zeros of a decimal number are dropped, but the ones digit always prints.
  assign skip     = (kind_q == KIND_DEC) && !started_q && (dec_nib == 4'd0) && !cnt_last;
  assign val32    = ArgW'(q_cmd_i.value[ValW-1:0]);

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    case (kind_q)
      KIND_DEC:  digit_chr = ChrZero + {4'b0, dec_nib};
      KIND_HEXL: digit_chr = hex_char(sh_q[ArgW-1 -: 4], 1'b0);
      KIND_HEXU: digit_chr = hex_char(sh_q[ArgW-1 -: 4], 1'b1);
      default:   digit_chr = ChrZero + {7'b0, sh_q[ArgW-1]};
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && q_cmd_i.kind == CMD_PRINT) begin
          state_d = (q_cmd_i.conv == KIND_DEC) ? BK_DABBLE : BK_DIGITS;
        end
      end
      BK_DABBLE: begin
        if (cnt_last) begin
          state_d = BK_DIGITS;
        end
      end
      BK_DIGITS: begin
        if (ofree && cnt_last) begin
          state_d = held_en_q ? BK_HELD : BK_IDLE;
        end
      end
      BK_HELD: begin
        if (ofree) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    q_pop_o   = 1'b0;
    kind_d    = kind_q;
    sh_d      = sh_q;
    val_d     = val_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    held_en_d = held_en_q;
    started_d = started_q;
    ovld_d    = ovld_q && !out_o.ready;
    ochr_d    = ochr_q;
    olast_d   = olast_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_cmd_i.kind == CMD_CHAR) begin
            if (ofree) begin
              q_pop_o = 1'b1;
              ovld_d  = 1'b1;
              ochr_d  = q_cmd_i.chr;
              olast_d = 1'b1;
            end
          end else begin
            q_pop_o   = 1'b1;
            kind_d    = q_cmd_i.conv;
            held_d    = q_cmd_i.chr;
            held_en_d = q_cmd_i.held_en;
            started_d = 1'b0;
            val_d     = q_cmd_i.value[ValW-1:0];
            bcd_d     = '0;
            case (q_cmd_i.conv)
              KIND_DEC: begin
                sh_d  = val32;
                cnt_d = CntW'(ValW);
              end
              KIND_BIN: begin
                sh_d  = val32 << (BinBits32 - q_cmd_i.nbits);
                cnt_d = q_cmd_i.nbits;
              end
              default: begin
                sh_d  = val32;
                cnt_d = HexDigits;
              end
            endcase
          end
        end
      end
      BK_DABBLE: begin
        bcd_d = {bcd_adj[BcdW-2:0], val_q[ValW-1]};
        val_d = val_q << 1;
        cnt_d = cnt_last ? CntW'(NumDig) : cnt_q - CntW'(1);
      end
      BK_DIGITS: begin
        if (skip) begin
          bcd_d = bcd_q << 4;
          cnt_d = cnt_q - CntW'(1);
        end else if (ofree) begin
          ovld_d    = 1'b1;
          ochr_d    = digit_chr;
          olast_d   = cnt_last && !held_en_q;
          started_d = 1'b1;
          bcd_d     = bcd_q << 4;
          sh_d      = (kind_q == KIND_BIN) ? sh_q << 1 : sh_q << 4;
          cnt_d     = cnt_q - CntW'(1);
        end
      end
      BK_HELD: begin
        if (ofree) begin
          ovld_d  = 1'b1;
          ochr_d  = held_q;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      ovld_q    <= 1'b0;
      cnt_q     <= '0;
      held_en_q <= 1'b0;
      started_q <= 1'b0;
      kind_q    <= KIND_DEC;
    end else begin
      state_q   <= state_d;
      ovld_q    <= ovld_d;
      cnt_q     <= cnt_d;
      held_en_q <= held_en_d;
      started_q <= started_d;
      kind_q    <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    val_q   <= val_d;
    bcd_q   <= bcd_d;
    held_q  <= held_d;
    ochr_q  <= ochr_d;
    olast_q <= olast_d;
  end

endmodule
